FILE: rtl/cnfsa_pkg.sv
// ----------------------------------------------------------------------------
// cnfsa_pkg: shared types and constants of the circular next-free allocator
// Request and response words, status codes and the bitmap word geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package cnfsa_pkg;

   // bitmap word geometry
   localparam int WORD_W    = 32;
   localparam int WORD_BITS = 5;

   // request kinds
   localparam logic REQ_TAKE  = 1'b0;
   localparam logic REQ_LEAVE = 1'b1;

   // response status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_FULL     = 2'd1;
   localparam logic [1:0] STAT_WAS_FREE = 2'd2;
   localparam logic [1:0] STAT_RANGE    = 2'd3;

   typedef struct packed {
      logic       req_type;
      logic [7:0] slot;
   } req_word_type;

   typedef struct packed {
      logic [7:0] result_slot;
      logic [1:0] status;
   } rsp_word_type;

   // which pass of the circular scan a word visit belongs to
   typedef struct packed {
      logic first;   // starting word: only bits above the preferred slot
      logic last;    // wrapped back to starting word: only bits below it
   } scan_ctl_type;

   typedef struct packed {
      logic                 found;
      logic [WORD_BITS-1:0] bit_idx;
   } scan_res_type;

endpackage

`default_nettype wire

FILE: rtl/cnfsa_map.sv
// ----------------------------------------------------------------------------
// cnfsa_map: slot occupancy bitmap
// One busy bit per slot, kept as 32-bit words; one word read, one bit written.
// ----------------------------------------------------------------------------
`default_nettype none

module cnfsa_map #(
   parameter int NUM_WORDS = 8,
   parameter int WORD_IW   = 3
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [WORD_IW-1:0]          rd_word,
   output logic [cnfsa_pkg::WORD_W-1:0]     rd_data,
   input  wire logic                        wr_en,
   input  wire logic                        wr_set,
   input  wire logic [7:0]                  wr_slot
);

   logic [cnfsa_pkg::WORD_W-1:0] words_ff [NUM_WORDS];
   logic [WORD_IW-1:0]           wr_word;

   assign wr_word = WORD_IW'(wr_slot >> cnfsa_pkg::WORD_BITS);
   assign rd_data = words_ff[rd_word];

   // all slots free after reset; single bit update otherwise
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < NUM_WORDS; w++) begin
            words_ff[w] <= '0;
         end
      end else if (wr_en) begin
         words_ff[wr_word][wr_slot[cnfsa_pkg::WORD_BITS-1:0]] <= wr_set;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/cnfsa_scan.sv
// ----------------------------------------------------------------------------
// cnfsa_scan: windowed find-first-free over one bitmap word
// Masks the word to the slot window of the current pass, then priority-encodes.
// ----------------------------------------------------------------------------
`default_nettype none

module cnfsa_scan (
   input  wire logic [cnfsa_pkg::WORD_W-1:0] word_bits,
   input  wire logic [8:0]                   base,
   input  wire logic [8:0]                   count,
   input  wire logic [7:0]                   pref_slot,
   input  wire cnfsa_pkg::scan_ctl_type      ctl,
   output cnfsa_pkg::scan_res_type           res
);

   logic [cnfsa_pkg::WORD_W-1:0] cand;

   // free and inside the window of this pass
   always_comb begin
      logic [8:0] g;
      for (int b = 0; b < cnfsa_pkg::WORD_W; b++) begin
         g = base + 9'(b);
         cand[b] = !word_bits[b] && (g < count)
                   && (!ctl.first || (g > {1'b0, pref_slot}))
                   && (!ctl.last  || (g < {1'b0, pref_slot}));
      end
   end

   // lowest candidate wins
   always_comb begin
      res = '0;
      for (int b = cnfsa_pkg::WORD_W - 1; b >= 0; b--) begin
         if (cand[b]) begin
            res.found   = 1'b1;
            res.bit_idx = cnfsa_pkg::WORD_BITS'(b);
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/circular_next_free_slot_allocator.sv
// ----------------------------------------------------------------------------
// circular_next_free_slot_allocator: circular first-fit slot allocator
// Busy bitmap with a word-at-a-time wrapped search for the next free slot.
// ----------------------------------------------------------------------------
// Usage:
//   Request words (req_word) are taken when start is high and busy is low.
//   A take names a preferred slot; the grant is that slot if free, else the
//   next free slot above it, wrapping to the lowest free slot. A leave frees
//   a busy slot. Each request gives one response word on rsp_word, marked by
//   a one-cycle rsp_valid strobe; the receiver must take it in that cycle.
//   The slot count register is written over csr_valid/csr_ready/csr_data;
//   csr_ready is high only while idle with no request offered on start.
// Timing:
//   Range errors, leaves and takes of a free preferred slot are answered
//   from the evaluate state. A take of a busy slot walks the bitmap one
//   32-bit word per cycle through the single scan unit, wrapping to word 0
//   and ending back at its starting word. One request at a time.
// Reset:
//   Synchronous; all slots free, slot count 256, no response pending.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_next_free_slot_allocator #(
   parameter int MAX_SLOTS = 256
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire cnfsa_pkg::req_word_type  req_word,
   output logic                          rsp_valid,
   output cnfsa_pkg::rsp_word_type       rsp_word,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [8:0]               csr_data
);

   localparam int DEPTH     = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;
   localparam int NUM_WORDS = (DEPTH + cnfsa_pkg::WORD_W - 1) / cnfsa_pkg::WORD_W;
   localparam int WORD_IW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EVAL = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   logic [1:0]               state_ff, state_in;
   logic [8:0]               count_ff;
   logic [8:0]               n_eff;
   cnfsa_pkg::req_word_type  req_ff, req_in;
   logic [WORD_IW-1:0]       word_ff, word_in;
   logic                     wrapped_ff, wrapped_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   cnfsa_pkg::rsp_word_type  rsp_ff, rsp_in;

   logic [WORD_IW-1:0]           start_word;
   logic [WORD_IW-1:0]           rd_word;
   logic [cnfsa_pkg::WORD_W-1:0] rd_data;
   logic                         wr_en, wr_set;
   logic [7:0]                   wr_slot;
   logic [8:0]                   base;
   logic [WORD_IW:0]             next_word;
   logic [8:0]                   next_base;
   cnfsa_pkg::scan_ctl_type      ctl;
   cnfsa_pkg::scan_res_type      res;
   logic                         pref_busy;

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !start;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // slot count in force, saturated to the bitmap depth
   assign n_eff = (count_ff > 9'(DEPTH)) ? 9'(DEPTH) : count_ff;

   assign start_word = WORD_IW'(req_ff.slot >> cnfsa_pkg::WORD_BITS);
   assign rd_word    = (state_ff == S_SCAN) ? word_ff : start_word;
   assign pref_busy  = rd_data[req_ff.slot[cnfsa_pkg::WORD_BITS-1:0]];

   // window of the current word visit
   assign base      = 9'(word_ff) << cnfsa_pkg::WORD_BITS;
   assign next_word = {1'b0, word_ff} + (WORD_IW+1)'(1);
   assign next_base = 9'(next_word) << cnfsa_pkg::WORD_BITS;
   assign ctl.first = !wrapped_ff && (word_ff == start_word);
   assign ctl.last  = wrapped_ff && (word_ff == start_word);

   cnfsa_map #(
      .NUM_WORDS (NUM_WORDS),
      .WORD_IW   (WORD_IW)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_word (rd_word),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_set  (wr_set),
      .wr_slot (wr_slot)
   );

   cnfsa_scan u_scan (
      .word_bits (rd_data),
      .base      (base),
      .count     (n_eff),
      .pref_slot (req_ff.slot),
      .ctl       (ctl),
      .res       (res)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      word_in      = word_ff;
      wrapped_in   = wrapped_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_set       = 1'b0;
      wr_slot      = req_ff.slot;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_word;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            rsp_in.result_slot = req_ff.slot;
            rsp_in.status      = cnfsa_pkg::STAT_OK;
            if ({1'b0, req_ff.slot} >= n_eff) begin
               rsp_in.status = cnfsa_pkg::STAT_RANGE;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else if (req_ff.req_type == cnfsa_pkg::REQ_LEAVE) begin
               if (pref_busy) begin
                  wr_en              = 1'b1;
                  rsp_in.result_slot = '0;
               end else begin
                  rsp_in.status = cnfsa_pkg::STAT_WAS_FREE;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (!pref_busy) begin
               wr_en        = 1'b1;
               wr_set       = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               word_in    = start_word;
               wrapped_in = 1'b0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (res.found) begin
               wr_slot            = 8'(base + 9'(res.bit_idx));
               wr_en              = 1'b1;
               wr_set             = 1'b1;
               rsp_in.result_slot = wr_slot;
               rsp_in.status      = cnfsa_pkg::STAT_OK;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end else if (ctl.last) begin
               rsp_in.result_slot = req_ff.slot;
               rsp_in.status      = cnfsa_pkg::STAT_FULL;
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end else if ((next_word >= (WORD_IW+1)'(NUM_WORDS)) || (next_base >= n_eff)) begin
               word_in    = '0;
               wrapped_in = 1'b1;
            end else begin
               word_in = WORD_IW'(next_word);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= 9'd256;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      word_ff    <= word_in;
      wrapped_ff <= wrapped_in;
      rsp_ff     <= rsp_in;
   end

endmodule

`default_nettype wire
